// ----- rtl/diffusion_tridiagonal_assembly_macros.svh -----
// Assertion macros shared by the checker of the tridiagonal assembly block.
// No dependencies.
`ifndef DIFFUSION_TRIDIAGONAL_ASSEMBLY_MACROS_SVH
`define DIFFUSION_TRIDIAGONAL_ASSEMBLY_MACROS_SVH

// Check a property on every rising edge outside reset.
`define DTA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check an implication on every rising edge outside reset.
`define DTA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/dta_pkg.sv -----
// Shared constants, types and arithmetic helpers of the tridiagonal assembly block.
// No dependencies.
package dta_pkg;

    localparam int MAX_CELLS = 4096;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = $clog2(MAX_CELLS);
    localparam int IDX_W     = 12;
    localparam int DVD_W     = 2 * DATA_W + 1;
    localparam int DVS_W     = DATA_W + 1;
    localparam int DCNT_W    = $clog2(DVD_W);
    localparam int SUM_W     = DATA_W + 4;

    localparam logic [2:0] ADDR_RIGHT_BOUNDARY = 3'd0;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_REM    = 8'b0000_0010,
        ST_RDIV   = 8'b0000_0100,
        ST_MULC   = 8'b0000_1000,
        ST_CSTART = 8'b0001_0000,
        ST_CDIV   = 8'b0010_0000,
        ST_ROW0   = 8'b0100_0000,
        ST_ROW1   = 8'b1000_0000
    } dta_state_t;

    typedef struct packed {
        logic load;
        logic rem_start;
        logic mul_coup;
        logic coup_start;
        logic ratio_latch;
        logic coup_latch;
        logic hold_first;
        logic hold_next;
        logic emit0;
        logic emit1;
    } dta_cmd_t;

    typedef struct packed {
        logic div_done;
        logic count_zero;
        logic last_in;
        logic last_eff;
        logic out_free;
    } dta_stat_t;

    function automatic logic [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(32'h7FFF_FFFF);
        lo = -SUM_W'(33'h0_8000_0000);
        if (v > hi)
            return 32'h7FFF_FFFF;
        else if (v < lo)
            return 32'h8000_0000;
        else
            return v[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] off_diag(input logic [DATA_W-1:0] c);
        if (c[DATA_W-1])
            return 32'h8000_0000;
        else
            return DATA_W'(-c);
    endfunction

endpackage

// ----- rtl/dta_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Depends on dta_pkg.
module dta_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [dta_pkg::DVD_W-1:0]  dividend,
    input  logic [dta_pkg::DVS_W-1:0]  divisor,
    output logic                       done,
    output logic [dta_pkg::DVD_W-1:0]  quotient
);
    import dta_pkg::*;

    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DVS_W:0]    trial;
    logic              ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        ge        = trial >= {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DCNT_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
            dvs_reg <= divisor;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/dta_dp.sv -----
// Datapath: input hold, multiplier, divider, held cell state and output register.
// Depends on dta_pkg and dta_div.
module dta_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  dta_pkg::dta_cmd_t          cmd,
    output dta_pkg::dta_stat_t         stat,
    input  logic                       right_boundary,
    input  logic [4*dta_pkg::DATA_W-1:0] in_data,
    input  logic                       in_last,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [3*dta_pkg::DATA_W+dta_pkg::IDX_W-1:0] out_data,
    output logic                       out_last
);
    import dta_pkg::*;

    logic [DATA_W-1:0]   d_reg, w_reg, st_reg, ss_reg;
    logic                last_reg;
    logic [2*DATA_W-1:0] prod_reg;
    logic [DATA_W-1:0]   r_reg, c_reg, rem_reg;
    logic [DATA_W-1:0]   held_ratio_reg, held_rem_reg, held_left_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                out_valid_reg;
    logic [DATA_W-1:0]   lower_reg, diag_reg, upper_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic                out_last_reg;

    logic [DATA_W-1:0]   mag, mul_a, mul_b;
    logic [DATA_W-1:0]   w_div;
    logic                rem_neg;
    logic [DVD_W-1:0]    dvd;
    logic [DVS_W-1:0]    dvs, coup_sum;
    logic                div_start, div_done;
    logic [DVD_W-1:0]    quo;
    logic [DATA_W-1:0]   ratio_val, coup_val, rem_val;
    logic [2*DATA_W-FRAC_BITS-1:0] rem_shift;
    logic [DATA_W-1:0]   rem_mag;
    logic signed [SUM_W-1:0] diag0, diag1, extra;

    assign rem_neg = ss_reg > st_reg;
    assign mag     = rem_neg ? DATA_W'(ss_reg - st_reg) : DATA_W'(st_reg - ss_reg);
    assign mul_a   = cmd.rem_start ? mag : held_ratio_reg;
    assign mul_b   = cmd.rem_start ? w_reg : r_reg;
    assign w_div   = (w_reg == '0) ? DATA_W'(1) : w_reg;

    assign coup_sum  = {1'b0, held_ratio_reg} + {1'b0, r_reg};
    assign div_start = cmd.rem_start | cmd.coup_start;
    assign dvd = cmd.rem_start ? DVD_W'({d_reg, {FRAC_BITS{1'b0}}}) : {prod_reg, 1'b0};
    assign dvs = cmd.rem_start ? {1'b0, w_div} : coup_sum;

    dta_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (quo)
    );

    assign ratio_val = (|quo[DVD_W-1:DATA_W]) ? '1 : quo[DATA_W-1:0];
    assign coup_val  = (coup_sum == '0) ? '0 :
                       ((|quo[DVD_W-1:DATA_W]) ? '1 : quo[DATA_W-1:0]);

    assign rem_shift = prod_reg[2*DATA_W-1:FRAC_BITS];
    assign rem_mag   = (rem_shift > (2*DATA_W-FRAC_BITS)'(33'h0_8000_0000))
                       ? 32'h8000_0000 : rem_shift[DATA_W-1:0];
    always_comb
    begin
        if (rem_neg)
            rem_val = DATA_W'(-rem_mag);
        else if (rem_mag[DATA_W-1])
            rem_val = 32'h7FFF_FFFF;
        else
            rem_val = rem_mag;
    end

    assign extra = right_boundary ? $signed({3'b0, r_reg, 1'b0}) : '0;
    assign diag0 = $signed({4'b0, held_left_reg}) + $signed({4'b0, c_reg})
                 + SUM_W'($signed(held_rem_reg));
    assign diag1 = $signed({4'b0, c_reg}) + SUM_W'($signed(rem_reg)) + extra;

    assign stat.div_done   = div_done;
    assign stat.count_zero = count_reg == '0;
    assign stat.last_in    = last_reg;
    assign stat.last_eff   = last_reg || (count_reg >= CNT_W'(MAX_CELLS - 1));
    assign stat.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            d_reg    <= in_data[DATA_W-1:0];
            w_reg    <= in_data[2*DATA_W-1:DATA_W];
            st_reg   <= in_data[3*DATA_W-1:2*DATA_W];
            ss_reg   <= in_data[4*DATA_W-1:3*DATA_W];
            last_reg <= in_last;
            c_reg    <= '0;
        end
        else if (cmd.coup_latch)
            c_reg <= coup_val;
        if (cmd.rem_start || cmd.mul_coup)
            prod_reg <= mul_a * mul_b;
        if (cmd.ratio_latch)
        begin
            r_reg   <= ratio_val;
            rem_reg <= rem_val;
        end
        if (cmd.emit0)
        begin
            lower_reg    <= (count_reg == CNT_W'(1)) ? '0 : off_diag(held_left_reg);
            diag_reg     <= sat32(diag0);
            upper_reg    <= off_diag(c_reg);
            idx_reg      <= IDX_W'(count_reg - 1'b1);
            out_last_reg <= 1'b0;
        end
        else if (cmd.emit1)
        begin
            lower_reg    <= off_diag(c_reg);
            diag_reg     <= sat32(diag1);
            upper_reg    <= '0;
            idx_reg      <= IDX_W'(count_reg);
            out_last_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_ratio_reg <= '0;
            held_rem_reg   <= '0;
            held_left_reg  <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.hold_first)
            begin
                held_ratio_reg <= ratio_val;
                held_rem_reg   <= rem_val;
                held_left_reg  <= '0;
                count_reg      <= CNT_W'(1);
            end
            else if (cmd.hold_next)
            begin
                held_ratio_reg <= r_reg;
                held_rem_reg   <= rem_reg;
                held_left_reg  <= c_reg;
                count_reg      <= count_reg + 1'b1;
            end
            else if (cmd.emit1)
            begin
                held_ratio_reg <= '0;
                held_rem_reg   <= '0;
                held_left_reg  <= '0;
                count_reg      <= '0;
            end
            if (cmd.emit0 || cmd.emit1)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {idx_reg, upper_reg, diag_reg, lower_reg};
    assign out_last  = out_last_reg;

endmodule

// ----- rtl/dta_ctrl.sv -----
// Controller state machine sequencing the datapath for each cell.
// Depends on dta_pkg.
module dta_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dta_pkg::dta_stat_t stat,
    output dta_pkg::dta_cmd_t  cmd
);
    import dta_pkg::*;

    dta_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_REM;
                end
            end
            ST_REM:
            begin
                cmd.rem_start = 1'b1;
                state_next    = ST_RDIV;
            end
            ST_RDIV:
            begin
                if (stat.div_done)
                begin
                    cmd.ratio_latch = 1'b1;
                    if (!stat.count_zero)
                        state_next = ST_MULC;
                    else if (stat.last_in)
                        state_next = ST_ROW1;
                    else
                    begin
                        cmd.hold_first = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            ST_MULC:
            begin
                cmd.mul_coup = 1'b1;
                state_next   = ST_CSTART;
            end
            ST_CSTART:
            begin
                cmd.coup_start = 1'b1;
                state_next     = ST_CDIV;
            end
            ST_CDIV:
            begin
                if (stat.div_done)
                begin
                    cmd.coup_latch = 1'b1;
                    state_next     = ST_ROW0;
                end
            end
            ST_ROW0:
            begin
                if (stat.out_free)
                begin
                    cmd.emit0 = 1'b1;
                    if (stat.last_eff)
                        state_next = ST_ROW1;
                    else
                    begin
                        cmd.hold_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            ST_ROW1:
            begin
                if (stat.out_free)
                begin
                    cmd.emit1  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = state_reg == ST_IDLE;

endmodule

// ----- rtl/diffusion_tridiagonal_assembly.sv -----
// Top level of the finite-volume tridiagonal assembly block: APB register, controller, datapath.
// Depends on dta_pkg, dta_ctrl and dta_dp.
//
//   channel  | direction | contents
//   s_axis   | in        | one cell: coefficients in tdata, last cell in tlast
//   m_axis   | out       | one matrix row: coefficients and index in tdata, last row in tlast
//   apb      | in/out    | right_boundary at byte address 0
//
// Two passes of the shared one-bit-per-cycle divider dominate the work on a
// cell; a first cell skips the coupling divide.
// The output register holds a row while the next cell is taken in; a stalled
// output holds the controller only when it must write the next row.
// Reset clears the held cell, the row count and right_boundary.
module diffusion_tridiagonal_assembly (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // diff_coef, cell_width, total_xs, self_scatter_xs
    input  logic         s_tlast,   // last_cell
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // lower_coef, diag_coef, upper_coef, row_index, zero pad
    output logic         m_tlast    // last_row
);
    import dta_pkg::*;

    dta_cmd_t  cmd;
    dta_stat_t stat;
    logic      right_boundary_reg;
    logic [3*DATA_W+IDX_W-1:0] row_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            right_boundary_reg <= 1'b0;
        else if (psel && penable && pwrite && pready && paddr == ADDR_RIGHT_BOUNDARY)
            right_boundary_reg <= pwdata[0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_RIGHT_BOUNDARY) ? {31'b0, right_boundary_reg} : '0;

    dta_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dta_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .right_boundary (right_boundary_reg),
        .in_data        (s_tdata),
        .in_last        (s_tlast),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_data       (row_data),
        .out_last       (m_tlast)
    );

    assign m_tdata = {4'b0, row_data};

endmodule

// ----- rtl/dta_checker.sv -----
// Port-level checker for the tridiagonal assembly block, bound to the top level.
// Depends on diffusion_tridiagonal_assembly_macros.svh.
`include "diffusion_tridiagonal_assembly_macros.svh"

module dta_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         pready,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata,
    input logic         m_tlast
);

    `DTA_ASSERT(a_pready_high, clk, rst_n, pready, "pready dropped")
    `DTA_ASSERT_IMP(a_out_hold, clk, rst_n, m_tvalid && !m_tready, ##1 (m_tvalid && $stable(m_tdata)), "stalled row changed")
    `DTA_ASSERT_IMP(a_last_upper, clk, rst_n, m_tvalid && m_tlast, m_tdata[95:64] == 32'd0, "last row upper nonzero")
    `DTA_ASSERT_IMP(a_first_lower, clk, rst_n, m_tvalid && m_tdata[107:96] == 12'd0, m_tdata[31:0] == 32'd0, "first row lower nonzero")
    `DTA_ASSERT_IMP(a_one_cell, clk, rst_n, s_tvalid && s_tready, ##1 !s_tready, "cell taken while busy")

endmodule

bind diffusion_tridiagonal_assembly dta_checker u_dta_checker (.*);

// ----- tb/tb_diffusion_tridiagonal_assembly.sv -----
// Self-checking testbench of the diffusion tridiagonal assembly block.
// Holds its own row predictor and a directed cell list, then random sweeps.
// Depends on dta_pkg and the RTL of diffusion_tridiagonal_assembly.
module tb_diffusion_tridiagonal_assembly;
    timeunit 1ns;
    timeprecision 1ps;
    import dta_pkg::*;

    typedef struct {
        bit [31:0] dc;
        bit [31:0] wd;
        bit [31:0] tx;
        bit [31:0] sx;
        bit        lc;
        bit        typed;
        bit [31:0] typed_diag;
    } cell_t;

    typedef struct {
        bit [31:0] lower;
        bit [31:0] diag;
        bit [31:0] upper;
        bit [11:0] idx;
        bit        last;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [111:0] m_tdata;
    logic         m_tlast;

    row_t      rows_pending[$];
    int        fail_count;
    int        stall_cycles;
    bit        quiet;
    bit        hold_off_req;
    bit        zero_flux;
    bit [31:0] held_ratio;
    longint    held_removal;
    bit [31:0] held_coupling;
    int        cells_held;

    diffusion_tridiagonal_assembly dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic bit [31:0] sat_s32(longint v);
        if (v > 64'sh7FFF_FFFF)
            return 32'h7FFF_FFFF;
        if (v < -64'sh8000_0000)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic bit [31:0] neg_coupling(bit [31:0] c);
        bit [32:0] m;
        m = (c > 32'h8000_0000) ? 33'h0_8000_0000 : {1'b0, c};
        return 32'(-m);
    endfunction

    function automatic bit [31:0] harmonic_coupling(bit [31:0] a, bit [31:0] b);
        bit [65:0] s;
        bit [65:0] q;
        s = a + b;
        if (s == 0)
            return 32'd0;
        q = (2 * (66'(a) * 66'(b))) / s;
        return (q > 66'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    task automatic predict_rows(cell_t c);
        bit [63:0] q;
        bit [63:0] w1;
        bit [63:0] mag;
        bit [63:0] p;
        bit [31:0] r;
        bit [31:0] cp;
        longint    rem;
        longint    extra;
        bit        lst;
        row_t      rw;
        w1 = (c.wd == 0) ? 64'd1 : 64'(c.wd);
        q = (64'(c.dc) << 16) / w1;
        r = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
        mag = (c.sx > c.tx) ? 64'(c.sx - c.tx) : 64'(c.tx - c.sx);
        p = (mag * 64'(c.wd)) >> 16;
        if (p > 64'h8000_0000)
            p = 64'h8000_0000;
        rem = (c.sx > c.tx) ? -longint'(p) : longint'(p);
        rem = longint'($signed(sat_s32(rem)));
        extra = zero_flux ? 2 * longint'(r) : 0;
        lst = c.lc;
        if (cells_held == 0)
        begin
            if (lst)
            begin
                rw = '{32'd0, sat_s32(rem + extra), 32'd0, 12'd0, 1'b1};
                if (c.typed)
                    rw.diag = c.typed_diag;
                rows_pending.push_back(rw);
                return;
            end
            held_ratio = r;
            held_removal = rem;
            held_coupling = 0;
            cells_held = 1;
            return;
        end
        if (cells_held >= MAX_CELLS - 1)
            lst = 1'b1;
        cp = harmonic_coupling(held_ratio, r);
        rw.lower = (cells_held == 1) ? 32'd0 : neg_coupling(held_coupling);
        rw.diag = sat_s32(longint'(held_coupling) + longint'(cp) + held_removal);
        rw.upper = neg_coupling(cp);
        rw.idx = 12'(cells_held - 1);
        rw.last = 1'b0;
        rows_pending.push_back(rw);
        if (lst)
        begin
            rw = '{neg_coupling(cp), sat_s32(longint'(cp) + rem + extra), 32'd0,
                   12'(cells_held), 1'b1};
            rows_pending.push_back(rw);
            cells_held = 0;
            held_ratio = 0;
            held_removal = 0;
            held_coupling = 0;
            return;
        end
        held_ratio = r;
        held_removal = rem;
        held_coupling = cp;
        cells_held++;
    endtask

    task automatic send_cell(cell_t c);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {c.sx, c.tx, c.wd, c.dc};
        s_tlast <= c.lc;
        do
            @(posedge clk);
        while (!s_tready);
        predict_rows(c);
    endtask

    task automatic write_boundary(bit v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_RIGHT_BOUNDARY;
        pwdata <= {31'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        zero_flux = v;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (rows_pending.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    function automatic bit [31:0] pick32();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 32'h000F_FFFF);
            3: return $urandom_range(32'h0000_4000, 32'h0040_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_sweep(int len, bit force_last);
        cell_t c;
        for (int k = 0; k < len; k++)
        begin
            c.dc = pick32();
            c.wd = ($urandom_range(0, 15) == 0) ? 32'd0 : pick32();
            c.tx = pick32();
            c.sx = ($urandom_range(0, 3) == 0) ? c.tx : pick32();
            c.lc = (k == len - 1) ? force_last
                                  : (force_last && ($urandom_range(0, 40) == 0));
            c.typed = 1'b0;
            send_cell(c);
            if (c.lc)
                break;
        end
    endtask

    task automatic receive_rows();
        int   gap;
        row_t got;
        row_t want;
        forever
        begin
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                repeat (500) @(posedge clk);
                hold_off_req = 1'b0;
            end
            gap = quiet ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            got = '{m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[107:96], m_tlast};
            if (rows_pending.size() == 0)
            begin
                $error("unexpected row, row_index %0d", got.idx);
                fail_count++;
                continue;
            end
            want = rows_pending.pop_front();
            if (got.lower !== want.lower)
            begin
                $error("lower_coef expected %h actual %h", want.lower, got.lower);
                fail_count++;
            end
            if (got.diag !== want.diag)
            begin
                $error("diag_coef expected %h actual %h", want.diag, got.diag);
                fail_count++;
            end
            if (got.upper !== want.upper)
            begin
                $error("upper_coef expected %h actual %h", want.upper, got.upper);
                fail_count++;
            end
            if (got.idx !== want.idx)
            begin
                $error("row_index expected %0d actual %0d", want.idx, got.idx);
                fail_count++;
            end
            if (got.last !== want.last)
            begin
                $error("last_row expected %0d actual %0d", want.last, got.last);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 20000)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        cell_t dir_cells[$];
        bit    hold_done;
        bit    pause_done;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        fail_count = 0;
        stall_cycles = 0;
        quiet = 1'b0;
        hold_off_req = 1'b0;
        zero_flux = 1'b0;
        held_ratio = 0;
        held_removal = 0;
        held_coupling = 0;
        cells_held = 0;
        hold_done = 1'b0;
        pause_done = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        fork
            receive_rows();
        join_none

        // single cells with a diagonal read off directly, then short sweeps
        dir_cells = '{
            '{32'd0, 32'd0, 32'h0005_0000, 32'd0, 1'b1, 1'b1, 32'd0},
            '{32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h8000_0000},
            '{32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b1, 1'b1, 32'h7FFF_FFFF},
            '{32'd0, 32'h0001_0000, 32'h0003_0000, 32'h0003_0000, 1'b1, 1'b1, 32'd0},
            '{32'hFFFF_FFFF, 32'd1, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0},
            '{32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0, 1'b1, 1'b0, 32'd0},
            '{32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 1'b0, 1'b0, 32'd0},
            '{32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 1'b0, 1'b0, 32'd0},
            '{32'd0, 32'h0001_0000, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0},
            '{32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'd0},
            '{32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd0, 1'b0, 1'b0, 32'd0},
            '{32'hFFFF_FFFF, 32'd1, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0},
            '{32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0, 32'd0}
        };
        write_boundary(1'b0);
        foreach (dir_cells[i])
            send_cell(dir_cells[i]);
        drain();
        write_boundary(1'b1);
        foreach (dir_cells[i])
        begin
            dir_cells[i].typed = 1'b0;
            send_cell(dir_cells[i]);
        end
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            write_boundary(ph[0]);
            quiet = (ph == 3);
            for (int n = 0; n < 130; )
            begin
                int len;
                len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12);
                if (ph == 2 && n >= 40 && !hold_done)
                begin
                    hold_done = 1'b1;
                    hold_off_req = 1'b1;
                end
                if (ph == 5 && n >= 60 && len > 1 && !pause_done)
                begin
                    pause_done = 1'b1;
                    send_sweep(1, 1'b0);
                    s_tvalid <= 1'b0;
                    while (rows_pending.size() != 0)
                        @(posedge clk);
                    send_sweep(len - 1, 1'b1);
                end
                else
                    send_sweep(len, 1'b1);
                n += len;
            end
            drain();
        end

        // one sweep long enough that the cell limit ends it
        quiet = 1'b1;
        write_boundary(1'b1);
        send_sweep(MAX_CELLS, 1'b0);
        drain();

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
